FILE: sv/pwsg_pkg.sv
// Shared types and constants for the periodic waveform sample generator.
// Used by the register file, the serial multiplier, the serial divider and the top level.
// Depends on nothing.
package pwsg_pkg;

    // Operand widths of the shared arithmetic path.
    localparam int AMP_W  = 16;
    localparam int MUL_W  = 17;
    localparam int PROD_W = AMP_W + MUL_W;
    localparam int DIV_W  = 16;
    localparam int QUO_W  = PROD_W - DIV_W;

    // Field widths.
    localparam int POS_W  = 13;
    localparam int IDX_W  = 12;
    localparam int CODE_W = 10;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Noise generator.
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // Fixed divisors and limits.
    localparam logic [DIV_W-1:0] NOISE_DIV = 16'd32768;
    localparam logic [DIV_W-1:0] DUTY_DIV  = 16'd100;
    localparam logic [7:0]       DUTY_MAX  = 8'd100;

    // Waveform modes.
    localparam logic [2:0] MODE_TRIANGLE = 3'd0;
    localparam logic [2:0] MODE_SQUARE   = 3'd1;
    localparam logic [2:0] MODE_RISE_SAW = 3'd2;
    localparam logic [2:0] MODE_FALL_SAW = 3'd3;
    localparam logic [2:0] MODE_DC       = 3'd4;
    localparam logic [2:0] MODE_NOISE    = 3'd5;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_WAVE_MODE     = 3'd0;
    localparam logic [2:0] REG_PERIOD_LENGTH = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd2;
    localparam logic [2:0] REG_OFFSET        = 3'd3;
    localparam logic [2:0] REG_DUTY_PERCENT  = 3'd4;
    localparam logic [2:0] REG_NOISE_SEED    = 3'd5;
    localparam logic [2:0] REG_DC_LEVEL      = 3'd6;

    typedef struct packed {
        logic [2:0]  wave_mode;
        logic [12:0] period_length;
        logic [15:0] amplitude;
        logic [15:0] offset;
        logic [7:0]  duty_percent;
        logic [31:0] noise_seed;
        logic [15:0] dc_level;
    } pwsg_cfg_t;

endpackage

FILE: sv/pwsg_regs.sv
// APB-style configuration register file of the waveform generator.
// Depends on pwsg_pkg for the register indexes and the configuration struct.
module pwsg_regs
    import pwsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output pwsg_cfg_t         cfg
);

    pwsg_cfg_t  cfg_reg;
    pwsg_cfg_t  cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_WAVE_MODE:     cfg_next.wave_mode     = pwdata[2:0];
                REG_PERIOD_LENGTH: cfg_next.period_length = pwdata[12:0];
                REG_AMPLITUDE:     cfg_next.amplitude     = pwdata[15:0];
                REG_OFFSET:        cfg_next.offset        = pwdata[15:0];
                REG_DUTY_PERCENT:  cfg_next.duty_percent  = pwdata[7:0];
                REG_NOISE_SEED:    cfg_next.noise_seed    = pwdata;
                REG_DC_LEVEL:      cfg_next.dc_level      = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_WAVE_MODE:     prdata = {29'd0, cfg_reg.wave_mode};
            REG_PERIOD_LENGTH: prdata = {19'd0, cfg_reg.period_length};
            REG_AMPLITUDE:     prdata = {16'd0, cfg_reg.amplitude};
            REG_OFFSET:        prdata = {16'd0, cfg_reg.offset};
            REG_DUTY_PERCENT:  prdata = {24'd0, cfg_reg.duty_percent};
            REG_NOISE_SEED:    prdata = cfg_reg.noise_seed;
            REG_DC_LEVEL:      prdata = {16'd0, cfg_reg.dc_level};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode     <= MODE_TRIANGLE;
            cfg_reg.period_length <= 13'd1024;
            cfg_reg.amplitude     <= 16'd0;
            cfg_reg.offset        <= 16'd512;
            cfg_reg.duty_percent  <= 8'd50;
            cfg_reg.noise_seed    <= 32'd0;
            cfg_reg.dc_level      <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/pwsg_serial_mult.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pwsg_pkg for the operand widths.
module pwsg_serial_mult
    import pwsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AMP_W-1:0]  a,
    input  logic [MUL_W-1:0]  m,
    output logic              busy,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_W);

    logic [AMP_W-1:0] a_reg;
    logic [AMP_W-1:0] a_next;
    logic [AMP_W-1:0] hi_reg;
    logic [AMP_W-1:0] hi_next;
    logic [MUL_W-1:0] lo_reg;
    logic [MUL_W-1:0] lo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [AMP_W:0]   sum;

    // The partial product sits in hi; the used multiplier bits leave lo to the right.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(AMP_W+1){1'b0}});

    always_comb
    begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = m;
            cnt_next  = CNT_W'(MUL_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[AMP_W:1];
            lo_next  = {sum[0], lo_reg[MUL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg};

endmodule

FILE: sv/pwsg_serial_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// The caller guarantees that the quotient fits QUO_W bits. Depends on pwsg_pkg.
module pwsg_serial_div
    import pwsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              busy,
    output logic [QUO_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIV_W-1:0] d_reg;
    logic [DIV_W-1:0] d_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [QUO_W-1:0] dq_reg;
    logic [QUO_W-1:0] dq_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [DIV_W+1:0] trial;

    // Dividend bits leave dq at the top while quotient bits enter at the bottom.
    assign trial = {1'b0, rem_reg, dq_reg[QUO_W-1]} - {2'b00, d_reg};

    always_comb
    begin
        d_next    = d_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            d_next    = divisor;
            rem_next  = dividend[PROD_W-1:QUO_W];
            dq_next   = dividend[QUO_W-1:0];
            cnt_next  = CNT_W'(QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W+1])
            begin
                rem_next = trial[DIV_W-1:0];
                dq_next  = {dq_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_W-2:0], dq_reg[QUO_W-1]};
                dq_next  = {dq_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

FILE: sv/periodic_waveform_sample_generator_unit.sv
// Top level of the periodic waveform sample generator: sequencer, index and noise state.
// Depends on pwsg_pkg, pwsg_regs, pwsg_serial_mult and pwsg_serial_div.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-----------------------------------
//   in       | receive   | in_valid / in_stall      | restart
//   out      | send      | out_valid / out_stall    | sample_code, sample_index, period_end
//   config   | receive   | psel penable pwrite      | paddr, pwdata, prdata (pready high)
//
// Each item goes from acceptance to the next acceptance through a setup step, the
// bit-serial multiplier, the bit-serial divider and the handover steps between them.
// Reset returns the registers to their documented values and the index and noise
// generator to zero. A stall on the output holds the finished item in the output
// register; the next item is still accepted and waits before the output stage.
module periodic_waveform_sample_generator_unit
    import pwsg_pkg::*;
#(
    parameter int MAX_PERIOD = 4096,
    parameter int DAC_TOP    = 1023
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CODE_W-1:0] sample_code,
    output logic [IDX_W-1:0]  sample_index,
    output logic              period_end
);

    // The period register cannot exceed its own field range, so the cap is taken
    // as the smaller of that range and the configured maximum.
    localparam int PTS_FIELD_MAX = (1 << POS_W) - 1;
    localparam int PTS_CAP       = (MAX_PERIOD > PTS_FIELD_MAX) ? PTS_FIELD_MAX : MAX_PERIOD;
    localparam int VAL_W         = 20;
    localparam logic signed [VAL_W-1:0] TOP_S = VAL_W'(DAC_TOP);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    pwsg_cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    // Sample state carried from one item to the next.
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [31:0]      lcg_reg;
    logic [31:0]      lcg_next;

    // The item being worked on.
    logic [POS_W-1:0] idx_reg;
    logic [POS_W-1:0] idx_next;
    logic [POS_W-1:0] pts_reg;
    logic [POS_W-1:0] pts_next;
    logic             last_reg;
    logic             last_next;
    logic             neg_reg;
    logic             neg_next;
    logic             q_zero_reg;
    logic             q_zero_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic              end_reg;
    logic              end_next;

    // Front end at acceptance.
    logic             accept;
    logic [POS_W-1:0] pts_eff;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] idx_eff;
    logic             last_eff;
    logic [31:0]      lcg_src;

    // Operand selection in the setup cycle.
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] q2;
    logic [POS_W-1:0] q3;
    logic [POS_W-1:0] q4;
    logic [POS_W-1:0] tri_m;
    logic             tri_neg;
    logic [7:0]       duty_c;
    logic [MUL_W-1:0] noise_mag;
    logic [AMP_W-1:0] op_a;
    logic [MUL_W-1:0] op_m;
    logic [DIV_W-1:0] op_d;
    logic             op_neg;

    // Arithmetic units.
    logic              mul_start;
    logic              mul_busy;
    logic [PROD_W-1:0] mul_product;
    logic              div_start;
    logic              div_busy;
    logic [QUO_W-1:0]  div_quotient;

    // Final value.
    logic signed [VAL_W-1:0] off_s;
    logic signed [VAL_W-1:0] amp_s;
    logic signed [VAL_W-1:0] quo_s;
    logic signed [VAL_W-1:0] val;
    logic [CODE_W-1:0]       code_clamped;
    logic                    out_free;

    pwsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwsg_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (op_a),
        .m       (op_m),
        .busy    (mul_busy),
        .product (mul_product)
    );

    pwsg_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (op_d),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // The block takes a new item only while the sequencer is at rest.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // A zero period counts as one sample, and a long one saturates at the cap.
    always_comb
    begin
        if (cfg.period_length == '0)
        begin
            pts_eff = POS_W'(1);
        end
        else if ({4'd0, cfg.period_length} > 17'(PTS_CAP))
        begin
            pts_eff = POS_W'(PTS_CAP);
        end
        else
        begin
            pts_eff = cfg.period_length;
        end
    end

    // An index left beyond a shortened period wraps to a period start.
    assign pos_start = restart ? '0 : position_reg;
    assign idx_eff   = (pos_start >= pts_eff) ? '0 : pos_start;
    assign last_eff  = (idx_eff == pts_eff - 1'b1);
    assign lcg_src   = (idx_eff == '0) ? cfg.noise_seed : lcg_reg;

    always_comb
    begin
        position_next = position_reg;
        lcg_next      = lcg_reg;
        idx_next      = idx_reg;
        pts_next      = pts_reg;
        last_next     = last_reg;
        if (accept)
        begin
            position_next = last_eff ? '0 : idx_eff + 1'b1;
            lcg_next      = 32'(LCG_MUL * lcg_src) + LCG_ADD;
            idx_next      = idx_eff;
            pts_next      = pts_eff;
            last_next     = last_eff;
        end
    end

    // Triangle quarters: rising, falling, falling below the offset, and rising
    // back. Samples beyond four quarters sit above four quarters, so the last
    // ramp takes the magnitude of a signed difference and flips its sign.
    assign q  = pts_reg >> 2;
    assign q2 = q << 1;
    assign q3 = q2 + q;
    assign q4 = q << 2;

    always_comb
    begin
        priority if (idx_reg < q)
        begin
            tri_m   = idx_reg;
            tri_neg = 1'b0;
        end
        else if (idx_reg < q2)
        begin
            tri_m   = q2 - idx_reg;
            tri_neg = 1'b0;
        end
        else if (idx_reg < q3)
        begin
            tri_m   = idx_reg - q2;
            tri_neg = 1'b1;
        end
        else if (idx_reg <= q4)
        begin
            tri_m   = q4 - idx_reg;
            tri_neg = 1'b1;
        end
        else
        begin
            tri_m   = idx_reg - q4;
            tri_neg = 1'b0;
        end
    end

    assign duty_c = (cfg.duty_percent > DUTY_MAX) ? DUTY_MAX : cfg.duty_percent;

    // Magnitude of the centred noise value; bit 15 clear means below centre.
    assign noise_mag = lcg_reg[15] ? {2'b00, lcg_reg[14:0]}
                                   : {1'b0, NOISE_DIV} - {1'b0, lcg_reg[15:0]};

    // Every mode becomes one product divided by one divisor. Modes without
    // arithmetic push a zero product through a divisor of one.
    always_comb
    begin
        op_a   = '0;
        op_m   = '0;
        op_d   = DIV_W'(1);
        op_neg = 1'b0;
        unique case (cfg.wave_mode)
            MODE_TRIANGLE:
            begin
                if (q != '0)
                begin
                    op_a   = cfg.amplitude;
                    op_m   = MUL_W'(tri_m);
                    op_d   = DIV_W'(q);
                    op_neg = tri_neg;
                end
            end
            MODE_SQUARE:
            begin
                // The high share ends at the quotient of period times duty by 100.
                op_a = AMP_W'(pts_reg);
                op_m = MUL_W'(duty_c);
                op_d = DUTY_DIV;
            end
            MODE_RISE_SAW, MODE_FALL_SAW:
            begin
                op_a = cfg.amplitude;
                op_m = MUL_W'({idx_reg, 1'b0});
                op_d = DIV_W'(pts_reg);
            end
            MODE_NOISE:
            begin
                op_a   = cfg.amplitude;
                op_m   = noise_mag;
                op_d   = NOISE_DIV;
                op_neg = !lcg_reg[15];
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        neg_next    = neg_reg;
        q_zero_next = q_zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                mul_start   = 1'b1;
                neg_next    = op_neg;
                q_zero_next = (q == '0);
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Final arithmetic on the quotient, in a signed width that holds the widest
    // offset plus twice the amplitude.
    assign off_s = VAL_W'(cfg.offset);
    assign amp_s = VAL_W'(cfg.amplitude);
    assign quo_s = VAL_W'(div_quotient);

    always_comb
    begin
        unique case (cfg.wave_mode)
            MODE_TRIANGLE:
            begin
                if (q_zero_reg)
                begin
                    val = off_s;
                end
                else
                begin
                    val = neg_reg ? off_s - quo_s : off_s + quo_s;
                end
            end
            MODE_SQUARE:
            begin
                val = ({4'd0, idx_reg} < div_quotient) ? off_s + amp_s : off_s - amp_s;
            end
            MODE_RISE_SAW: val = off_s + quo_s - amp_s;
            MODE_FALL_SAW: val = off_s + amp_s - quo_s;
            MODE_DC:       val = VAL_W'(cfg.dc_level);
            MODE_NOISE:    val = neg_reg ? off_s - quo_s : off_s + quo_s;
            default:       val = off_s;
        endcase
    end

    always_comb
    begin
        priority if (val < 0)
        begin
            code_clamped = '0;
        end
        else if (val > TOP_S)
        begin
            code_clamped = TOP_S[CODE_W-1:0];
        end
        else
        begin
            code_clamped = val[CODE_W-1:0];
        end
    end

    // The output register is free when empty or being taken in this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        index_next     = index_reg;
        end_next       = end_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            code_next      = code_clamped;
            index_next     = idx_reg[IDX_W-1:0];
            end_next       = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            position_reg  <= '0;
            lcg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pts_reg    <= pts_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
        q_zero_reg <= q_zero_next;
        code_reg   <= code_next;
        index_reg  <= index_next;
        end_reg    <= end_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample_code  = code_reg;
    assign sample_index = index_reg;
    assign period_end   = end_reg;

    // A new result appears only from the final sequencer step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the final step");

    // The multiplier and the divider never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    // An accepted item closes the input until its work is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && (state_reg == S_SETUP)))
        else $error("input not closed after an accepted item");

    // The divider is started only once the multiplier has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (!mul_busy && (state_reg == S_MUL)))
        else $error("divider started before the product was ready");

endmodule

FILE: verif/pwsg_sample_checker.sv
`timescale 1ns / 1ps
// Sample checker for the periodic waveform sample generator: it watches the register port
// and both item channels, predicts each sample and compares it. Depends on pwsg_pkg.
module pwsg_sample_checker
    import pwsg_pkg::*;
#(
    parameter int PERIOD_CAP = 4096,
    parameter int CODE_TOP   = 1023
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              restart,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CODE_W-1:0] sample_code,
    input  logic [IDX_W-1:0]  sample_index,
    input  logic              period_end,
    input  logic              wrap_up,
    output int                mismatch_count,
    output int                pending_samples,
    output int                samples_checked
);

    localparam logic [31:0] NOISE_MUL = 32'd1664525;
    localparam logic [31:0] NOISE_INC = 32'd1013904223;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  index;
        logic              last;
    } sample_t;

    pwsg_cfg_t         cfg;
    logic [IDX_W-1:0]  next_pos;
    logic [31:0]       lcg_state;
    sample_t           expected_samples[$];
    sample_t           oldest;
    logic              tail_done;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [31:0] register_value(input logic [2:0] idx);
        case (idx)
            REG_WAVE_MODE:     return {29'd0, cfg.wave_mode};
            REG_PERIOD_LENGTH: return {19'd0, cfg.period_length};
            REG_AMPLITUDE:     return {16'd0, cfg.amplitude};
            REG_OFFSET:        return {16'd0, cfg.offset};
            REG_DUTY_PERCENT:  return {24'd0, cfg.duty_percent};
            REG_NOISE_SEED:    return cfg.noise_seed;
            REG_DC_LEVEL:      return {16'd0, cfg.dc_level};
            default:           return 32'd0;
        endcase
    endfunction

    // Works out the sample for one accepted item and advances the index and noise state.
    function automatic sample_t compute_sample(input logic restart_bit);
        longint  pts;
        longint  idx;
        longint  amp;
        longint  off;
        longint  q;
        longint  duty;
        longint  low;
        longint  val;
        sample_t s;

        pts = cfg.period_length;
        if (pts == 0) pts = 1;
        if (pts > PERIOD_CAP) pts = PERIOD_CAP;
        if (restart_bit) next_pos = '0;
        idx = next_pos;
        if (idx >= pts) idx = 0;

        lcg_state = ((idx == 0) ? cfg.noise_seed : lcg_state) * NOISE_MUL + NOISE_INC;

        amp = cfg.amplitude;
        off = cfg.offset;
        case (cfg.wave_mode)
            MODE_TRIANGLE: begin
                q = pts / 4;
                if (q == 0) val = off;
                else if (idx < q) val = off + amp * idx / q;
                else if (idx < 2 * q) val = off + amp * (2 * q - idx) / q;
                else if (idx < 3 * q) val = off - (amp * (idx - 2 * q) / q);
                else val = off - (amp * (4 * q - idx) / q);
            end
            MODE_SQUARE: begin
                duty = cfg.duty_percent;
                if (duty > 100) duty = 100;
                val = (idx < pts * duty / 100) ? off + amp : off - amp;
            end
            MODE_RISE_SAW: val = off + (2 * amp * idx / pts) - amp;
            MODE_FALL_SAW: val = off + amp - (2 * amp * idx / pts);
            MODE_DC:       val = cfg.dc_level;
            MODE_NOISE: begin
                low = lcg_state[15:0];
                val = off + (amp * (low - 32768) / 32768);
            end
            default:       val = off;
        endcase

        if (val < 0) s.code = '0;
        else if (val > CODE_TOP) s.code = CODE_W'(CODE_TOP);
        else s.code = val[CODE_W-1:0];
        s.index = idx[IDX_W-1:0];
        s.last = (idx == pts - 1);
        next_pos = s.last ? '0 : IDX_W'(idx + 1);
        return s;
    endfunction

    initial
    begin
        mismatch_count = 0;
        samples_checked = 0;
        pending_samples = 0;
        tail_done = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.wave_mode     = MODE_TRIANGLE;
            cfg.period_length = 13'd1024;
            cfg.amplitude     = 16'd0;
            cfg.offset        = 16'd512;
            cfg.duty_percent  = 8'd50;
            cfg.noise_seed    = 32'd0;
            cfg.dc_level      = 16'd0;
            next_pos          = '0;
            lcg_state         = 32'd0;
            expected_samples.delete();
            pending_samples   = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_WAVE_MODE:     cfg.wave_mode = pwdata[2:0];
                        REG_PERIOD_LENGTH: cfg.period_length = pwdata[12:0];
                        REG_AMPLITUDE:     cfg.amplitude = pwdata[15:0];
                        REG_OFFSET:        cfg.offset = pwdata[15:0];
                        REG_DUTY_PERCENT:  cfg.duty_percent = pwdata[7:0];
                        REG_NOISE_SEED:    cfg.noise_seed = pwdata;
                        REG_DC_LEVEL:      cfg.dc_level = pwdata[15:0];
                        default: ;
                    endcase
                end
                else if (prdata !== register_value(paddr[ADDR_W-1:2]))
                begin
                    report_mismatch($sformatf("register %0d read 0x%h, expected 0x%h",
                        paddr[ADDR_W-1:2], prdata, register_value(paddr[ADDR_W-1:2])));
                end
            end

            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_mismatch($sformatf("sample with nothing expected: code %0d index %0d",
                        sample_code, sample_index));
                end
                else
                begin
                    oldest = expected_samples.pop_front();
                    if (sample_code !== oldest.code)
                        report_mismatch($sformatf("sample_code %0d, expected %0d (index %0d)",
                            sample_code, oldest.code, oldest.index));
                    if (sample_index !== oldest.index)
                        report_mismatch($sformatf("sample_index %0d, expected %0d",
                            sample_index, oldest.index));
                    if (period_end !== oldest.last)
                        report_mismatch($sformatf("period_end %0b, expected %0b (index %0d)",
                            period_end, oldest.last, oldest.index));
                    samples_checked++;
                end
            end

            if (in_valid && !in_stall)
                expected_samples.push_back(compute_sample(restart));

            if (wrap_up && !tail_done)
            begin
                tail_done = 1'b1;
                if (expected_samples.size() != 0)
                    report_mismatch($sformatf("%0d samples never arrived",
                        expected_samples.size()));
            end

            pending_samples = expected_samples.size();
        end
    end

endmodule

FILE: verif/tb_periodic_waveform_sample_generator_unit.sv
`timescale 1ns / 1ps
// Top of the testbench for the periodic waveform sample generator: clock, reset, register
// programming, item stimulus and verdict. Depends on pwsg_pkg, the block and pwsg_sample_checker.
module tb_periodic_waveform_sample_generator_unit;
    import pwsg_pkg::*;

    localparam int PERIOD_CAP    = 4096;
    localparam int CODE_TOP      = 1023;
    localparam int RANDOM_ITEMS  = 1300;
    // The closing stretch runs one whole period of a medium length, plus a little, so that
    // the period wraps under an unbroken stream of items.
    localparam int TAIL_PERIOD   = 256;
    localparam int TAIL_ITEMS    = TAIL_PERIOD + 3;
    // This covers the last item with plenty of margin.
    localparam int SETTLE_CYCLES = 80;
    // Roughly 1700 items at their worst, plus the register traffic, taken several times over.
    localparam int CYCLE_LIMIT   = 1_500_000;

    // Modes 6 and 7 have no waveform of their own and should give the clamped offset.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    // The register slot just past the last real register; writes to it must be ignored.
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              restart;
    logic              out_valid;
    logic              out_stall;
    logic [CODE_W-1:0] sample_code;
    logic [IDX_W-1:0]  sample_index;
    logic              period_end;

    logic              wrap_up;
    int                mismatch_count;
    int                pending_samples;
    int                samples_checked;

    // Idling odds: one burst in this many chances; zero switches idling off.
    int                gap_odds;
    int                stall_odds;
    int                restart_odds;
    int                items_sent;
    int                settings_applied;
    int                cycle_count;
    int                random_goal;
    int                phase_len;

    periodic_waveform_sample_generator_unit #(
        .MAX_PERIOD (PERIOD_CAP),
        .DAC_TOP    (CODE_TOP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_code  (sample_code),
        .sample_index (sample_index),
        .period_end   (period_end)
    );

    pwsg_sample_checker #(
        .PERIOD_CAP (PERIOD_CAP),
        .CODE_TOP   (CODE_TOP)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .restart         (restart),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sample_code     (sample_code),
        .sample_index    (sample_index),
        .period_end      (period_end),
        .wrap_up         (wrap_up),
        .mismatch_count  (mismatch_count),
        .pending_samples (pending_samples),
        .samples_checked (samples_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // One register access: a setup cycle, then an access cycle held until pready. Every
    // access starts by waiting for an edge, so that back-to-back calls never assign psel
    // twice in the same time step.
    task automatic reg_access(input logic write, input logic [2:0] idx,
                              input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic pwsg_cfg_t make_settings(input logic [2:0] mode, input int pts,
                                                input int amp, input int off, input int duty,
                                                input logic [31:0] seed, input int dc);
        pwsg_cfg_t s;
        s.wave_mode     = mode;
        s.period_length = pts[12:0];
        s.amplitude     = amp[15:0];
        s.offset        = off[15:0];
        s.duty_percent  = duty[7:0];
        s.noise_seed    = seed;
        s.dc_level      = dc[15:0];
        return s;
    endfunction

    function automatic int extreme_level();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 511;
            3:       return 512;
            4:       return CODE_TOP;
            default: return 65535;
        endcase
    endfunction

    // Random settings lean towards short periods so that whole periods fit in a phase, with
    // the occasional long period, zero length and over-range length thrown in.
    function automatic pwsg_cfg_t random_settings();
        pwsg_cfg_t s;
        int        pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) s.period_length = 13'($urandom_range(1, 40));
        else if (pick < 17) s.period_length = 13'($urandom_range(41, 300));
        else if (pick < 19) s.period_length = 13'($urandom_range(301, PERIOD_CAP));
        else if ($urandom_range(0, 1) == 0) s.period_length = 13'd0;
        else s.period_length = 13'($urandom_range(PERIOD_CAP + 1, 8191));

        if ($urandom_range(0, 9) == 0) s.wave_mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_B));
        else s.wave_mode = 3'($urandom_range(MODE_TRIANGLE, MODE_NOISE));

        case ($urandom_range(0, 3))
            0:       s.amplitude = 16'($urandom_range(0, 600));
            1:       s.amplitude = 16'($urandom);
            default: s.amplitude = 16'(extreme_level());
        endcase
        case ($urandom_range(0, 9))
            0, 1:    s.offset = 16'($urandom);
            2:       s.offset = 16'(extreme_level());
            default: s.offset = 16'($urandom_range(0, CODE_TOP));
        endcase
        s.duty_percent = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 100));
        s.noise_seed   = $urandom;
        s.dc_level     = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                                                       16'($urandom_range(0, CODE_TOP));
        return s;
    endfunction

    // Writes all seven registers, sometimes with rubbish in the bits above each field, and
    // then reads every one back so that the checker can compare the stored values.
    task automatic apply_settings(input pwsg_cfg_t s);
        logic [31:0] junk;
        junk = ($urandom_range(0, 1) == 0) ? $urandom : 32'd0;
        reg_access(1'b1, REG_WAVE_MODE,     {junk[31:3], s.wave_mode});
        reg_access(1'b1, REG_PERIOD_LENGTH, {junk[31:13], s.period_length});
        reg_access(1'b1, REG_AMPLITUDE,     {junk[31:16], s.amplitude});
        reg_access(1'b1, REG_OFFSET,        {junk[31:16], s.offset});
        reg_access(1'b1, REG_DUTY_PERCENT,  {junk[31:8], s.duty_percent});
        reg_access(1'b1, REG_NOISE_SEED,    s.noise_seed);
        reg_access(1'b1, REG_DC_LEVEL,      {junk[31:16], s.dc_level});
        for (int r = REG_WAVE_MODE; r <= REG_DC_LEVEL; r++)
            reg_access(1'b0, r[2:0], 32'd0);
        settings_applied++;
    endtask

    // Offers one item and holds it until the block takes it. Valid is only lowered when a
    // gap is wanted, so a run of items keeps valid high without a glitch.
    task automatic send_item(input logic restart_bit);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Stops offering items and waits until every expected sample has been seen. The count is
    // read on the falling edge, clear of the checker's updates on the rising edge.
    task automatic drain_samples();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_samples != 0);
        @(posedge clk);
    endtask

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 6;
            default: return 15;
        endcase
    endfunction

    // The receiving side stalls in bursts, as often as stall_odds says.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that has not finished by the limit is counted as a failure.
    initial
    begin
        cycle_count = 0;
        do
        begin
            @(posedge clk);
            cycle_count++;
        end
        while (cycle_count < CYCLE_LIMIT);
        $display("Run timed out after %0d cycles with %0d samples outstanding",
                 cycle_count, pending_samples);
        $display("** periodic_waveform_sample_generator_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        restart          = 1'b0;
        wrap_up          = 1'b0;
        gap_odds         = 0;
        stall_odds       = 0;
        restart_odds     = 0;
        items_sent       = 0;
        settings_applied = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the reset values are read back and two samples taken with
        // them: a zero amplitude triangle sits on the offset.
        for (int r = REG_WAVE_MODE; r <= REG_DC_LEVEL; r++)
            reg_access(1'b0, r[2:0], 32'd0);
        stall_odds = 5;
        send_item(1'b0);
        send_item(1'b1);

        // A plain square wave, leaving the index part way into a 16-sample period.
        drain_samples();
        apply_settings(make_settings(MODE_SQUARE, 16, 100, 500, 50, 32'd0, 0));
        repeat (5) send_item(1'b0);

        // Shortening the period below the current index must wrap it back to a period
        // start. Four samples then walk all four triangle ramps at full amplitude, clamped at
        // both ends, and the last one closes the period.
        drain_samples();
        apply_settings(make_settings(MODE_TRIANGLE, 4, 65535, 0, 50, 32'd0, 0));
        repeat (4) send_item(1'b0);

        // A triangle shorter than four samples is flat at the offset.
        drain_samples();
        apply_settings(make_settings(MODE_TRIANGLE, 3, 65535, 700, 50, 32'd0, 0));
        repeat (2) send_item(1'b0);

        // Duty above a hundred percent is held at a hundred; zero duty is always low.
        drain_samples();
        apply_settings(make_settings(MODE_SQUARE, 2, 300, 600, 255, 32'd0, 0));
        repeat (2) send_item(1'b0);
        drain_samples();
        apply_settings(make_settings(MODE_SQUARE, 2, 300, 600, 0, 32'd0, 0));
        send_item(1'b1);

        // A zero period length counts as one sample, so every sample ends a period.
        drain_samples();
        apply_settings(make_settings(MODE_RISE_SAW, 0, 65535, 65535, 50, 32'd0, 0));
        send_item(1'b0);

        // An over-range period length saturates at the largest period.
        drain_samples();
        apply_settings(make_settings(MODE_FALL_SAW, 8191, 65535, 0, 50, 32'd0, 0));
        repeat (2) send_item(1'b1);

        // The DC level clamps at the top code.
        drain_samples();
        apply_settings(make_settings(MODE_DC, 1, 0, 0, 50, 32'd0, 65535));
        send_item(1'b0);

        // Noise from an all-ones seed over a five-sample period.
        drain_samples();
        apply_settings(make_settings(MODE_NOISE, 5, 65535, 512, 50, 32'hFFFF_FFFF, 0));
        repeat (3) send_item(1'b0);

        // The two spare modes give the offset; a write past the last register changes
        // nothing, though the next settings rewrite every register before reading them back.
        drain_samples();
        apply_settings(make_settings(MODE_SPARE_A, 7, 400, 333, 50, 32'd0, 0));
        send_item(1'b0);
        drain_samples();
        reg_access(1'b1, REG_UNMAPPED, 32'hFFFF_FFFF);
        apply_settings(make_settings(MODE_SPARE_B, 7, 400, 65535, 50, 32'd0, 0));
        send_item(1'b0);

        // Random part: phases of random settings and idling, with mostly unbroken runs of
        // samples and the odd restart. Now and then a phase pauses half way until every
        // sample has come back.
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            drain_samples();
            if ($urandom_range(0, 5) == 0)
                reg_access(1'b1, REG_UNMAPPED, $urandom);
            apply_settings(random_settings());
            gap_odds     = pick_odds();
            stall_odds   = pick_odds();
            restart_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 8 : 40);
            phase_len    = $urandom_range(10, 100);
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == phase_len / 2 && $urandom_range(0, 3) == 0)
                    drain_samples();
                send_item(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            end
        end

        // Closing stretch with no idling on either side: one full period and a few samples
        // more, starting from a restart.
        drain_samples();
        gap_odds   = 0;
        stall_odds = 0;
        apply_settings(make_settings(MODE_TRIANGLE, TAIL_PERIOD, 700, 512, 50, $urandom, 0));
        send_item(1'b1);
        repeat (TAIL_ITEMS) send_item(1'b0);

        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);
        wrap_up <= 1'b1;
        @(posedge clk);
        @(negedge clk);

        $display("Checked %0d samples from %0d items under %0d register settings,",
                 samples_checked, items_sent, settings_applied);
        $display("covering all waveforms, spare modes, period lengths 0 to 8191 and restarts.");
        if (mismatch_count == 0)
            $display("** periodic_waveform_sample_generator_unit: PASSED **");
        else
            $display("** periodic_waveform_sample_generator_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
sv/pwsg_pkg.sv
sv/pwsg_regs.sv
sv/pwsg_serial_mult.sv
sv/pwsg_serial_div.sv
sv/periodic_waveform_sample_generator_unit.sv
verif/pwsg_sample_checker.sv
verif/tb_periodic_waveform_sample_generator_unit.sv
